// ===== rtl/core/modular_arithmetic_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit assertion macros
// Shared concurrent assertion forms for the modular arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Operation codes, sequencer states and widths shared by the unit.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int DATA_W = 32;
    localparam int WIDE_W = 64;
    localparam int CNT_W  = 6;

    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_POW = 3'd4,
        KIND_INV = 3'd5,
        KIND_NEG = 3'd6,
        KIND_RED = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RA,
        ST_RA_W,
        ST_RB,
        ST_RB_W,
        ST_DISP,
        ST_POW,
        ST_MUL_P,
        ST_MUL_R,
        ST_MUL_W,
        ST_RS,
        ST_RS_W,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        STEP_ACC,
        STEP_SQR,
        STEP_FINAL
    } t_step;

endpackage

// ===== rtl/core/mau_rem.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit remainder engine
// Restoring bit-serial remainder of a 64-bit dividend by a 32-bit modulus.
// ----------------------------------------------------------------------------
module mau_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mau_pkg::WIDE_W-1:0]  i_dividend,
    input  logic [mau_pkg::DATA_W-1:0]  i_modulus,
    output logic                        o_done,
    output logic [mau_pkg::DATA_W-1:0]  o_rem
);
    import mau_pkg::*;

    logic [DATA_W-1:0] r_rem;
    logic [WIDE_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_next;

    always_comb begin
        w_trial = {r_rem, r_div[WIDE_W-1]};
        if (w_trial >= {1'b0, i_modulus}) begin
            w_next = w_trial - {1'b0, i_modulus};
        end else begin
            w_next = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == {CNT_W{1'b1}});
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == {CNT_W{1'b1}}) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_next[DATA_W-1:0];
            r_div <= {r_div[WIDE_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/modular_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, divide, power, inverse, negate and signed reduce
// modulo a run-time modulus, using one multiplier and one remainder engine.
// ----------------------------------------------------------------------------
// The input channel takes one transaction when i_valid is high and o_stall is
// low; o_stall stays high from acceptance until the result has been taken.
// The result channel presents o_result with o_valid, and the transaction
// completes when i_stall is low. While the receiver stalls, the result is held
// and no new input is taken. The modulus is written through the configuration
// channel (i_cfg_valid, o_cfg_ready, always ready); the user must write it only
// while the unit is idle; the unit itself does not enforce this. Each remainder
// runs on the bit-serial remainder engine. Add, subtract and negate reduce both
// operands, multiply then also reduces their product, and signed reduce takes
// one remainder. Power, inverse and divide step through the exponent bits with
// modular products, up to 128 products with a full 64-bit exponent. A zero
// modulus gives 0 in the cycle after acceptance.
// Reset sets the modulus to 2 and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "modular_arithmetic_unit_defines.svh"

module modular_arithmetic_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_kind,
    input  logic [mau_pkg::DATA_W-1:0]        i_left,
    input  logic [mau_pkg::DATA_W-1:0]        i_right,
    input  logic [mau_pkg::WIDE_W-1:0]        i_exponent,
    input  logic signed [mau_pkg::WIDE_W-1:0] i_signed_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [mau_pkg::DATA_W-1:0]        o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mau_pkg::DATA_W-1:0]        i_cfg_data
);
    import mau_pkg::*;

    t_state            r_state, n_state;
    t_kind             r_kind;
    t_step             r_step, n_step;
    logic [DATA_W-1:0] r_modulus;
    logic [DATA_W-1:0] r_left, r_right;
    logic [WIDE_W-1:0] r_sv;
    logic [WIDE_W-1:0] r_exp, n_exp;
    logic [DATA_W-1:0] r_a, n_a, r_b, n_b;
    logic [DATA_W-1:0] r_acc, n_acc, r_base, n_base;
    logic [DATA_W-1:0] r_opx, n_opx, r_opy, n_opy;
    logic [WIDE_W-1:0] r_prod;
    logic [DATA_W-1:0] r_res, n_res;

    logic              w_accept;
    logic              w_rem_start;
    logic [WIDE_W-1:0] w_rem_din;
    logic              w_rem_done;
    logic [DATA_W-1:0] w_rem;
    logic [DATA_W:0]   w_sum;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_pm2;

    assign w_accept    = i_valid && (r_state == ST_IDLE);
    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    assign w_sum  = {1'b0, r_a} + {1'b0, r_b};
    assign w_diff = {1'b0, r_a} + {1'b0, r_modulus} - {1'b0, r_b};
    assign w_pm2  = r_modulus - DATA_W'(2);

    assign w_rem_start = (r_state == ST_RA) || (r_state == ST_RB) ||
                         (r_state == ST_RS) || (r_state == ST_MUL_R);

    always_comb begin
        case (r_state)
            ST_RA:   w_rem_din = {{(WIDE_W-DATA_W){1'b0}}, r_left};
            ST_RB:   w_rem_din = {{(WIDE_W-DATA_W){1'b0}}, r_right};
            ST_RS:   w_rem_din = r_sv[WIDE_W-1] ? (WIDE_W'(0) - r_sv) : r_sv;
            default: w_rem_din = r_prod;
        endcase
    end

    mau_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_rem_din),
        .i_modulus  (r_modulus),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (r_modulus == '0) begin
                        n_state = ST_OUT;
                    end else if (t_kind'(i_kind) == KIND_RED) begin
                        n_state = ST_RS;
                    end else begin
                        n_state = ST_RA;
                    end
                end
            end
            ST_RA:   n_state = ST_RA_W;
            ST_RA_W: if (w_rem_done) n_state = ST_RB;
            ST_RB:   n_state = ST_RB_W;
            ST_RB_W: if (w_rem_done) n_state = ST_DISP;
            ST_DISP: begin
                case (r_kind)
                    KIND_MUL: n_state = ST_MUL_P;
                    KIND_POW, KIND_INV, KIND_DIV: n_state = ST_POW;
                    default: n_state = ST_OUT;
                endcase
            end
            ST_POW: begin
                if (r_exp == '0 && r_kind != KIND_DIV) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_MUL_P;
                end
            end
            ST_MUL_P: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_MUL_W;
            ST_MUL_W: begin
                if (w_rem_done) begin
                    case (r_step)
                        STEP_ACC: n_state = ST_MUL_P;
                        STEP_SQR: n_state = ST_POW;
                        default:  n_state = ST_OUT;
                    endcase
                end
            end
            ST_RS:   n_state = ST_RS_W;
            ST_RS_W: if (w_rem_done) n_state = ST_OUT;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_step = r_step;
        n_exp  = r_exp;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_base = r_base;
        n_opx  = r_opx;
        n_opy  = r_opy;
        n_res  = r_res;
        case (r_state)
            ST_IDLE: begin
                n_res = '0;
                n_exp = i_exponent;
            end
            ST_RA_W: if (w_rem_done) n_a = w_rem;
            ST_RB_W: if (w_rem_done) n_b = w_rem;
            ST_DISP: begin
                n_acc  = (r_modulus == DATA_W'(1)) ? '0 : DATA_W'(1);
                n_base = r_a;
                case (r_kind)
                    KIND_ADD: begin
                        n_res = (w_sum >= {1'b0, r_modulus}) ?
                                DATA_W'(w_sum - {1'b0, r_modulus}) : w_sum[DATA_W-1:0];
                    end
                    KIND_SUB: begin
                        n_res = (r_a >= r_b) ? (r_a - r_b) : w_diff[DATA_W-1:0];
                    end
                    KIND_NEG: n_res = (r_a == '0) ? '0 : (r_modulus - r_a);
                    KIND_MUL: begin
                        n_opx  = r_a;
                        n_opy  = r_b;
                        n_step = STEP_FINAL;
                    end
                    KIND_INV: n_exp = {{(WIDE_W-DATA_W){1'b0}}, w_pm2};
                    KIND_DIV: begin
                        n_exp  = {{(WIDE_W-DATA_W){1'b0}}, w_pm2};
                        n_base = r_b;
                    end
                    default: n_res = r_res;
                endcase
            end
            ST_POW: begin
                if (r_exp == '0) begin
                    n_res  = r_acc;
                    n_opx  = r_a;
                    n_opy  = r_acc;
                    n_step = STEP_FINAL;
                end else if (r_exp[0]) begin
                    n_opx  = r_acc;
                    n_opy  = r_base;
                    n_step = STEP_ACC;
                end else begin
                    n_opx  = r_base;
                    n_opy  = r_base;
                    n_step = STEP_SQR;
                end
            end
            ST_MUL_W: begin
                if (w_rem_done) begin
                    case (r_step)
                        STEP_ACC: begin
                            n_acc  = w_rem;
                            n_opx  = r_base;
                            n_opy  = r_base;
                            n_step = STEP_SQR;
                        end
                        STEP_SQR: begin
                            n_base = w_rem;
                            n_exp  = {1'b0, r_exp[WIDE_W-1:1]};
                        end
                        default: n_res = w_rem;
                    endcase
                end
            end
            ST_RS_W: begin
                if (w_rem_done) begin
                    if (r_sv[WIDE_W-1] && w_rem != '0) begin
                        n_res = r_modulus - w_rem;
                    end else begin
                        n_res = w_rem;
                    end
                end
            end
            default: n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_modulus <= DATA_W'(2);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_modulus <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= t_kind'(i_kind);
            r_left  <= i_left;
            r_right <= i_right;
            r_sv    <= i_signed_value;
        end
        if (r_state == ST_MUL_P) begin
            r_prod <= r_opx * r_opy;
        end
        r_step <= n_step;
        r_exp  <= n_exp;
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_base <= n_base;
        r_opx  <= n_opx;
        r_opy  <= n_opy;
        r_res  <= n_res;
    end

    `MAU_ASSERT_NOW(a_result_range, i_clk, i_rst_n, o_valid, (r_modulus == '0) || (o_result < r_modulus), "result not below modulus")
    `MAU_ASSERT_NOW(a_busy_stall, i_clk, i_rst_n, (r_state != ST_IDLE), o_stall, "input taken while busy")
    `MAU_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, w_rem_done && (r_state == ST_MUL_W), w_rem < r_modulus, "remainder not below modulus")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Sends directed and random operations through the input channel under
// several moduli and idle patterns, predicts every result in the bench and
// compares each result transaction with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import mau_pkg::*;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [2:0]               i_kind;
    logic [DATA_W-1:0]        i_left;
    logic [DATA_W-1:0]        i_right;
    logic [WIDE_W-1:0]        i_exponent;
    logic signed [WIDE_W-1:0] i_signed_value;
    logic                     o_valid;
    logic                     i_stall;
    logic [DATA_W-1:0]        o_result;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [DATA_W-1:0]        i_cfg_data;

    logic [DATA_W-1:0] modulus_q;
    logic [DATA_W-1:0] residues_due[$];
    int                errors;
    int                send_idle_pct;
    int                recv_idle_pct;

    modular_arithmetic_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_left         (i_left),
        .i_right        (i_right),
        .i_exponent     (i_exponent),
        .i_signed_value (i_signed_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic [31:0] mod_mul(logic [31:0] x, logic [31:0] y, logic [31:0] m);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, y};
        return 32'(p % {32'd0, m});
    endfunction

    function automatic logic [31:0] mod_pow(logic [31:0] base, logic [63:0] e, logic [31:0] m);
        logic [31:0] acc;
        acc = 32'(64'd1 % {32'd0, m});
        while (e != 64'd0) begin
            if (e[0]) acc = mod_mul(acc, base, m);
            base = mod_mul(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [31:0] modular_result(t_kind kind, logic [31:0] left,
                                                   logic [31:0] right, logic [63:0] e,
                                                   logic [63:0] sval, logic [31:0] m);
        logic [31:0] a;
        logic [31:0] b;
        logic [32:0] s;
        logic [63:0] mag;
        logic [31:0] r;
        if (m == 32'd0) return 32'd0;
        a = left % m;
        b = right % m;
        case (kind)
            KIND_ADD: begin
                s = {1'b0, a} + {1'b0, b};
                return (s >= {1'b0, m}) ? 32'(s - {1'b0, m}) : s[31:0];
            end
            KIND_SUB: return (a >= b) ? a - b : 32'({1'b0, a} + {1'b0, m} - {1'b0, b});
            KIND_MUL: return mod_mul(a, b, m);
            KIND_DIV: return mod_mul(a, mod_pow(b, {32'd0, m - 32'd2}, m), m);
            KIND_POW: return mod_pow(a, e, m);
            KIND_INV: return mod_pow(a, {32'd0, m - 32'd2}, m);
            KIND_NEG: return (a == 32'd0) ? 32'd0 : m - a;
            default: begin
                if (!sval[63]) return 32'(sval % {32'd0, m});
                mag = 64'd0 - sval;
                r = 32'(mag % {32'd0, m});
                return (r == 32'd0) ? 32'd0 : m - r;
            end
        endcase
    endfunction

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (residues_due.size() == 0) begin
                $error("unexpected result %0d", o_result);
                errors++;
            end else begin
                want = residues_due.pop_front();
                if (o_result !== want) begin
                    $error("result: expected %0d, actual %0d", want, o_result);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(t_kind kind, logic [31:0] left, logic [31:0] right,
                             logic [63:0] e, logic [63:0] sval);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_kind         = kind;
        i_left         = left;
        i_right        = right;
        i_exponent     = e;
        i_signed_value = sval;
        do @(posedge i_clk); while (o_stall);
        residues_due.push_back(modular_result(kind, left, right, e, sval, modulus_q));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (residues_due.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_modulus(logic [31:0] m);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        modulus_q = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_modulus();
        send_item(KIND_INV, 32'd0, 32'd0, 64'd0, 64'd0);
        send_item(KIND_ADD, 32'hFFFF_FFFF, 32'd1, 64'd0, 64'd0);
        send_item(KIND_RED, 32'd0, 32'd0, 64'd0, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_degenerate_moduli();
        write_modulus(32'd0);
        send_item(KIND_POW, 32'd5, 32'd3, 64'd7, 64'd9);
        write_modulus(32'd1);
        send_item(KIND_POW, 32'd5, 32'd3, 64'd0, 64'd9);
        send_item(KIND_RED, 32'd5, 32'd3, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_wide_modulus();
        write_modulus(32'hFFFF_FFFF);
        send_item(KIND_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 64'd0, 64'd0);
        send_item(KIND_SUB, 32'd1, 32'hFFFF_FFFE, 64'd0, 64'd0);
        send_item(KIND_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 64'd0, 64'd0);
        send_item(KIND_DIV, 32'd12345, 32'd678, 64'd0, 64'd0);
    endtask

    task automatic test_prime_modulus();
        write_modulus(32'd4294967291);
        send_item(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 64'd0);
        send_item(KIND_SUB, 32'd0, 32'hFFFF_FFFF, 64'd0, 64'd0);
        send_item(KIND_MUL, 32'hFFFF_FFFA, 32'h8000_0001, 64'd0, 64'd0);
        send_item(KIND_DIV, 32'd1000, 32'd7, 64'd0, 64'd0);
        send_item(KIND_DIV, 32'd1000, 32'd0, 64'd0, 64'd0);
        send_item(KIND_POW, 32'd3, 32'd0, 64'd0, 64'd0);
        send_item(KIND_POW, 32'hDEAD_BEEF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_item(KIND_INV, 32'd0, 32'd0, 64'd0, 64'd0);
        send_item(KIND_INV, 32'd2, 32'd0, 64'd0, 64'd0);
        send_item(KIND_NEG, 32'd0, 32'd0, 64'd0, 64'd0);
        send_item(KIND_NEG, 32'd1, 32'd0, 64'd0, 64'd0);
        send_item(KIND_RED, 32'd0, 32'd0, 64'd0, 64'h8000_0000_0000_0000);
        send_item(KIND_RED, 32'd0, 32'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(KIND_RED, 32'd0, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFB);
    endtask

    task automatic test_random_ops(int count);
        logic [63:0] e;
        logic [31:0] left;
        logic [31:0] right;
        for (int i = 0; i < count; i++) begin
            left  = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
            right = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
            e = {$urandom, $urandom};
            if ($urandom_range(15) != 0) e = e >> $urandom_range(64, 40);
            send_item(t_kind'($urandom_range(7)), left, right, e, {$urandom, $urandom});
        end
    endtask

    task automatic pick_modulus();
        case ($urandom_range(3))
            0: write_modulus(32'd4294967291);
            1: write_modulus(32'd65521);
            2: write_modulus($urandom_range(1000, 2));
            default: write_modulus($urandom);
        endcase
    endtask

    initial begin
        errors         = 0;
        modulus_q      = 32'd2;
        send_idle_pct  = 27;
        recv_idle_pct  = 70;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_kind         = KIND_ADD;
        i_left         = '0;
        i_right        = '0;
        i_exponent     = '0;
        i_signed_value = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_modulus();
        test_degenerate_moduli();
        test_wide_modulus();
        test_prime_modulus();

        pick_modulus();
        test_random_ops(13);
        pick_modulus();
        test_random_ops(13);
        send_idle_pct = 70;
        recv_idle_pct = 27;
        pick_modulus();
        test_random_ops(13);
        pick_modulus();
        test_random_ops(13);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pick_modulus();
        test_random_ops(12);
        write_modulus(32'd4294967291);
        test_random_ops(12);

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (errors == 0 && residues_due.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
